[sv/tkfv_pkg.sv]
// Package for the top-k frequent values block: sizes, payload types and
// the frequency saturation helper. No dependencies.
package tkfv_pkg;

   localparam int MAX_DISTINCT = 64;
   localparam int COUNT_BITS   = 16;
   localparam int IDX_W        = $clog2(MAX_DISTINCT);
   localparam int USED_W       = $clog2(MAX_DISTINCT + 1);
   localparam int TOPC_W       = 7;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        frequency;
      logic               last_out;
      logic               overflow;
   } rsp_type;

   // Clamp an internal count to the 16-bit result field.
   function automatic logic [15:0] to_freq(input logic [COUNT_BITS-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      if (wide > 64'h0000_0000_0000_FFFF) begin
         return 16'hFFFF;
      end
      return wide[15:0];
   endfunction

endpackage

[sv/tkfv_front.sv]
// Front end of the top-k frequent values block: takes input transfers and
// holds them in a short queue for the back end. Depends on tkfv_pkg.
module tkfv_front import tkfv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    item_valid,
   output req_type item_data,
   input  logic    item_pop
);

   req_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                push;
   logic                pop;

   assign busy       = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (fill_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

[sv/tkfv_back.sv]
// Back end of the top-k frequent values block: counting table with a
// parallel key match, and the selection walk that emits results.
// Depends on tkfv_pkg.
module tkfv_back import tkfv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [TOPC_W-1:0] top_count,
   input  logic              item_valid,
   input  req_type           item_data,
   output logic              item_pop,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_UPD, S_SCAN, S_OUT} state_type;

   state_type               state_ff;
   logic signed [31:0]      key_ff [MAX_DISTINCT];
   logic [COUNT_BITS-1:0]   cnt_ff [MAX_DISTINCT];
   logic [USED_W-1:0]       used_ff;
   logic                    drop_ff;
   logic [MAX_DISTINCT-1:0] mask_ff;
   req_type                 cur_ff;
   logic [USED_W-1:0]       n_ff;
   logic [USED_W-1:0]       r_ff;
   logic [USED_W-1:0]       idx_ff;
   logic [IDX_W-1:0]        best_ff;
   logic [COUNT_BITS-1:0]   best_cnt_ff;
   logic                    found_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff;

   logic [MAX_DISTINCT-1:0] hit;
   logic                    any_hit;
   logic [USED_W-1:0]       used_in;
   logic [TOPC_W-1:0]       want;
   logic [IDX_W-1:0]        scan_i;
   logic                    take;

   always_comb begin
      for (int i = 0; i < MAX_DISTINCT; i++) begin
         hit[i] = (USED_W'(i) < used_ff) && (key_ff[i] == cur_ff.value);
      end
      any_hit = |hit;
      used_in = (!any_hit && used_ff < USED_W'(MAX_DISTINCT)) ? used_ff + 1'b1 : used_ff;
      want    = (top_count == '0) ? TOPC_W'(1) : top_count;
      scan_i  = idx_ff[IDX_W-1:0];
      take    = !mask_ff[scan_i] && (!found_ff || cnt_ff[scan_i] > best_cnt_ff);
   end

   assign item_pop   = (state_ff == S_IDLE) && item_valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         drop_ff       <= 1'b0;
         mask_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == S_OUT);
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  cur_ff   <= item_data;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               for (int i = 0; i < MAX_DISTINCT; i++) begin
                  if (hit[i] && cnt_ff[i] != COUNT_MAX) begin
                     cnt_ff[i] <= cnt_ff[i] + 1'b1;
                  end
               end
               if (!any_hit) begin
                  if (used_ff < USED_W'(MAX_DISTINCT)) begin
                     key_ff[used_ff[IDX_W-1:0]] <= cur_ff.value;
                     cnt_ff[used_ff[IDX_W-1:0]] <= COUNT_BITS'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
               end
               used_ff <= used_in;
               if (cur_ff.last_in) begin
                  n_ff     <= (USED_W'(want) < used_in) ? USED_W'(want) : used_in;
                  r_ff     <= '0;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_SCAN: begin
               if (take) begin
                  found_ff    <= 1'b1;
                  best_ff     <= scan_i;
                  best_cnt_ff <= cnt_ff[scan_i];
               end
               if (idx_ff + 1'b1 == used_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_OUT: begin
               rsp_ff.key         <= key_ff[best_ff];
               rsp_ff.frequency   <= to_freq(best_cnt_ff);
               rsp_ff.last_out    <= (r_ff + 1'b1 == n_ff);
               rsp_ff.overflow    <= drop_ff;
               if (r_ff + 1'b1 == n_ff) begin
                  used_ff  <= '0;
                  drop_ff  <= 1'b0;
                  mask_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  mask_ff[best_ff] <= 1'b1;
                  r_ff     <= r_ff + 1'b1;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MAX_DISTINCT))
      else $error("table fill beyond its size");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_OUT) |-> (r_ff < n_ff && n_ff != '0))
      else $error("emit rank outside the result count");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_OUT))
      else $error("result strobe without an emit step");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.last_out) |-> (used_ff == '0 && mask_ff == '0))
      else $error("table not cleared after the final result");

endmodule

[sv/top_k_frequent_values.sv]
// Top level of the top-k frequent values block: configuration register,
// front-end queue and back-end counting table. Depends on tkfv_pkg,
// tkfv_front and tkfv_back.
//
// Usage: values are offered on req_data with start; a transfer happens at
// a clock edge where start is high and busy is low. The final value of a
// set carries last_in. The front end queues up to two transfers, so the
// source sees busy only while the queue is full.
// In the back end, the idle state pops each value from the queue, and
// the update state does the parallel key match and count update across
// all table entries. After the marked value, the back end walks the
// table once per result (one entry per cycle across every stored
// distinct value, then an output step that emits the result).
// Each result appears on rsp_data for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it, so there is no back pressure on
// the result side. top_count is written through csr_we / csr_wdata while
// the block is idle; a value of zero acts as one.
// Reset is synchronous: the queue empties, the table is empty, the
// overflow flag clears and top_count returns to one. The key and count
// stores are not cleared; only entries written in the current set are read.
module top_k_frequent_values import tkfv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [TOPC_W-1:0] csr_wdata
);

   logic [TOPC_W-1:0] top_count_ff;
   logic              item_valid;
   req_type           item_data;
   logic              item_pop;

   // The user must write the register only while no set is in flight; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOPC_W'(1);
      end else if (csr_we) begin
         top_count_ff <= csr_wdata;
      end
   end

   tkfv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop)
   );

   tkfv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .top_count  (top_count_ff),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
